// ===== design/mpla_pkg.sv =====
// Package for the multiprecision limb ALU: field widths, default sizes,
// mode codes, controller states and the controller/datapath command structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpla_pkg;

    localparam int LIMB_BITS    = 15;
    localparam int LIMBS_DEF    = 256;
    localparam int NUMBERS_DEF  = 4;
    localparam int MODE_W       = 3;
    localparam int SLOT_W       = 2;
    localparam int IDX_W        = 8;
    localparam int LEAD_W       = 9;
    localparam int BIT_CNT_W    = $clog2(LIMB_BITS);

    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SUB   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MUL   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DIV   = 3'd5;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISP, S_RDCAP,
        S_ARD, S_AEX1, S_AEX2,
        S_DRD, S_DLD, S_DSTEP, S_DWR, S_RCHK,
        S_RRD, S_RWR, S_LRD, S_LEAD, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        LOP_HOLD, LOP_LAST, LOP_IDX, LOP_INC, LOP_DEC
    } t_limb_op;

    typedef enum logic [1:0] {
        RS_AB_LIMB, RS_C_LIMB, RS_C_IDX
    } t_rd_sel;

    typedef enum logic [2:0] {
        WS_NONE, WS_WRITE_LIMB, WS_ARITH, WS_QUOT, WS_ROUND, WS_CLEAR
    } t_wr_sel;

    typedef enum logic [2:0] {
        RES_NONE, RES_READ, RES_LEAD, RES_LEAD_MAX, RES_OVF_SET
    } t_res_op;

    typedef struct packed {
        logic     load;
        t_limb_op limb_op;
        logic     rd_en;
        t_rd_sel  rd_sel;
        t_wr_sel  wr_sel;
        logic     prod_ld;
        logic     carry_clr;
        logic     rem_clr;
        logic     div_init;
        logic     div_step;
        logic     ovf_upd;
        t_res_op  res;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              idx_ok;
        logic              x_zero;
        logic              limb_first;
        logic              limb_last;
        logic              round_up;
        logic              round_carry;
        logic              clr_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/mpla_in_if.sv =====
// Input channel of the multiprecision limb ALU: valid/ready plus one operation.
// Depends on mpla_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mpla_in_if
    import mpla_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [SLOT_W-1:0]    src_a;
    logic [SLOT_W-1:0]    src_b;
    logic [SLOT_W-1:0]    dst;
    logic [IDX_W-1:0]     limb_index;
    logic [LIMB_BITS-1:0] limb_value;
    logic [LIMB_BITS-1:0] scalar;

    modport source (output valid, mode, src_a, src_b, dst, limb_index, limb_value, scalar,
                    input ready);
    modport sink (input valid, mode, src_a, src_b, dst, limb_index, limb_value, scalar,
                  output ready);
endinterface

`default_nettype wire

// ===== design/mpla_out_if.sv =====
// Output channel of the multiprecision limb ALU: valid/ready plus one result.
// Depends on mpla_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mpla_out_if
    import mpla_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [LIMB_BITS-1:0] read_value;
    logic [LEAD_W-1:0]    leading_index;
    logic                 overflow;

    modport source (output valid, read_value, leading_index, overflow, input ready);
    modport sink (input valid, read_value, leading_index, overflow, output ready);
endinterface

`default_nettype wire

// ===== design/multiprecision_limb_alu_unit.sv =====
// Top level of the multiprecision limb ALU: controller, datapath, result register.
// Depends on mpla_pkg, mpla_in_if, mpla_out_if, mpla_ctrl and mpla_dp.
//
// The unit holds NUMBERS fixed-point numbers of LIMBS limbs of 15 bits, limb 0
// being the integer part and most significant. Each input transaction is one
// operation and returns one result transaction. After reset the limb memory is
// swept to zero, one entry per cycle, all NUMBERS*LIMBS entries (1024 by
// default), and no transaction is taken until that is done. Add, subtract and
// multiply walk the limbs from least to most significant through the single
// write port of the memory; each limb is read, operated on and written back
// with carry. Divide runs a bit-serial restoring divider over each limb from
// the start limb to the end, then, when rounding up, a carry ripple over the
// limbs it reaches, and a final read of the start limb for the leading index.
// The divider loop sets the rate. A finished result waits in an output
// register, so a new transaction is taken while the previous result is still
// unclaimed.
`timescale 1ns / 1ps
`default_nettype none

module multiprecision_limb_alu_unit
    import mpla_pkg::*;
#(
    parameter int LIMBS   = LIMBS_DEF,
    parameter int NUMBERS = NUMBERS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mpla_in_if.sink      i_in,
    mpla_out_if.source   o_out
);

    t_cmd                 w_cmd;
    t_sts                 w_sts;
    logic                 w_in_ready;
    logic                 w_push;
    logic                 w_out_free;
    logic [LIMB_BITS-1:0] w_read_value;
    logic [LEAD_W-1:0]    w_leading_index;
    logic                 w_overflow;

    logic                 r_out_valid;
    logic [LIMB_BITS-1:0] r_read_value;
    logic [LEAD_W-1:0]    r_leading_index;
    logic                 r_overflow;

    // the result register is free when empty or drained this cycle
    assign w_out_free = !r_out_valid || o_out.ready;

    mpla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready),
        .o_push     (w_push)
    );

    mpla_dp #(
        .LIMBS   (LIMBS),
        .NUMBERS (NUMBERS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_mode          (i_in.mode),
        .i_src_a         (i_in.src_a),
        .i_src_b         (i_in.src_b),
        .i_dst           (i_in.dst),
        .i_limb_index    (i_in.limb_index),
        .i_limb_value    (i_in.limb_value),
        .i_scalar        (i_in.scalar),
        .o_sts           (w_sts),
        .o_read_value    (w_read_value),
        .o_leading_index (w_leading_index),
        .o_overflow      (w_overflow)
    );

    // hold the result until the sink takes it; load a new one on push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_read_value    <= w_read_value;
            r_leading_index <= w_leading_index;
            r_overflow      <= w_overflow;
        end
    end

    assign i_in.ready          = w_in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.read_value    = r_read_value;
    assign o_out.leading_index = r_leading_index;
    assign o_out.overflow      = r_overflow;

endmodule

`default_nettype wire

// ===== design/mpla_ctrl.sv =====
// Controller of the multiprecision limb ALU: sequences limb walks, the
// bit-serial divide and the rounding ripple. Depends on mpla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpla_ctrl
    import mpla_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_free,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_in_ready,
    output logic      o_push
);

    t_state                r_state, n_state;
    logic [BIT_CNT_W-1:0]  r_bit, n_bit;
    logic                  w_bit_last;

    assign w_bit_last = (r_bit == BIT_CNT_W'(LIMB_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_DISP;
            S_DISP: begin
                priority if (i_sts.mode == MODE_WRITE) begin
                    n_state = S_DONE;
                end else if (i_sts.mode == MODE_READ) begin
                    n_state = i_sts.idx_ok ? S_RDCAP : S_DONE;
                end else if (i_sts.mode == MODE_ADD || i_sts.mode == MODE_SUB ||
                             i_sts.mode == MODE_MUL) begin
                    n_state = S_ARD;
                end else if (i_sts.mode == MODE_DIV) begin
                    n_state = (i_sts.x_zero || !i_sts.idx_ok) ? S_DONE : S_DRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RDCAP: n_state = S_DONE;
            S_ARD:   n_state = S_AEX1;
            S_AEX1:  n_state = S_AEX2;
            S_AEX2:  n_state = i_sts.limb_first ? S_DONE : S_ARD;
            S_DRD:   n_state = S_DLD;
            S_DLD: begin
                n_state = S_DSTEP;
                n_bit   = '0;
            end
            S_DSTEP: begin
                n_bit = r_bit + 1'b1;
                if (w_bit_last) n_state = S_DWR;
            end
            S_DWR:   n_state = i_sts.limb_last ? S_RCHK : S_DRD;
            S_RCHK:  n_state = i_sts.round_up ? S_RRD : S_LRD;
            S_RRD:   n_state = S_RWR;
            S_RWR: begin
                if (!i_sts.round_carry || i_sts.limb_first) n_state = S_LRD;
                else n_state = S_RRD;
            end
            S_LRD:   n_state = S_LEAD;
            S_LEAD:  n_state = S_DONE;
            S_DONE:  if (i_out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_push     = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.wr_sel = WS_CLEAR;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DISP: begin
                priority if (i_sts.mode == MODE_WRITE) begin
                    o_cmd.wr_sel = WS_WRITE_LIMB;
                end else if (i_sts.mode == MODE_READ) begin
                    o_cmd.rd_en  = i_sts.idx_ok;
                    o_cmd.rd_sel = RS_C_IDX;
                end else if (i_sts.mode == MODE_ADD || i_sts.mode == MODE_SUB ||
                             i_sts.mode == MODE_MUL) begin
                    o_cmd.limb_op   = LOP_LAST;
                    o_cmd.carry_clr = 1'b1;
                end else if (i_sts.mode == MODE_DIV) begin
                    priority if (i_sts.x_zero) begin
                        o_cmd.res = RES_OVF_SET;
                    end else if (!i_sts.idx_ok) begin
                        o_cmd.res = RES_LEAD_MAX;
                    end else begin
                        o_cmd.limb_op = LOP_IDX;
                        o_cmd.rem_clr = 1'b1;
                    end
                end else begin
                    o_cmd.res = RES_NONE;
                end
            end
            S_RDCAP: o_cmd.res = RES_READ;
            S_ARD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_AB_LIMB;
            end
            S_AEX1: o_cmd.prod_ld = 1'b1;
            S_AEX2: begin
                o_cmd.wr_sel = WS_ARITH;
                if (i_sts.limb_first) o_cmd.ovf_upd = 1'b1;
                else o_cmd.limb_op = LOP_DEC;
            end
            S_DRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_AB_LIMB;
            end
            S_DLD:   o_cmd.div_init = 1'b1;
            S_DSTEP: o_cmd.div_step = 1'b1;
            S_DWR: begin
                o_cmd.wr_sel = WS_QUOT;
                if (!i_sts.limb_last) o_cmd.limb_op = LOP_INC;
            end
            S_RCHK: if (i_sts.round_up) o_cmd.limb_op = LOP_LAST;
            S_RRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_C_LIMB;
            end
            S_RWR: begin
                o_cmd.wr_sel = WS_ROUND;
                if (i_sts.round_carry) begin
                    if (i_sts.limb_first) o_cmd.ovf_upd = 1'b1;
                    else o_cmd.limb_op = LOP_DEC;
                end
            end
            S_LRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_C_IDX;
            end
            S_LEAD: o_cmd.res = RES_LEAD;
            S_DONE: o_push = i_out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/mpla_dp.sv =====
// Datapath of the multiprecision limb ALU: limb memory, operand registers,
// add/sub/multiply carry chain, bit-serial divider and result registers.
// Depends on mpla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpla_dp
    import mpla_pkg::*;
#(
    parameter int LIMBS   = LIMBS_DEF,
    parameter int NUMBERS = NUMBERS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic [SLOT_W-1:0]    i_src_a,
    input  wire logic [SLOT_W-1:0]    i_src_b,
    input  wire logic [SLOT_W-1:0]    i_dst,
    input  wire logic [IDX_W-1:0]     i_limb_index,
    input  wire logic [LIMB_BITS-1:0] i_limb_value,
    input  wire logic [LIMB_BITS-1:0] i_scalar,
    output t_sts                      o_sts,
    output logic [LIMB_BITS-1:0]      o_read_value,
    output logic [LEAD_W-1:0]         o_leading_index,
    output logic                      o_overflow
);

    localparam int LB    = LIMB_BITS;
    localparam int DEPTH = NUMBERS * LIMBS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = (LIMBS > 2) ? $clog2(LIMBS) : 1;
    localparam int PW    = 2 * LB + 1;
    localparam int TW    = 2 * LB + 2;

    function automatic logic [SLOT_W-1:0] slot_mod(input logic [SLOT_W-1:0] s);
        return (32'(s) >= NUMBERS) ? SLOT_W'(32'(s) - NUMBERS) : s;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [SLOT_W-1:0] s,
                                              input logic [LW-1:0] l);
        return AW'(AW'(s) * AW'(LIMBS)) + AW'(l);
    endfunction

    logic [LB-1:0]     mem [DEPTH];

    logic [MODE_W-1:0] r_mode;
    logic [SLOT_W-1:0] r_sa, r_sb, r_sc;
    logic [IDX_W-1:0]  r_idx;
    logic [LB-1:0]     r_val, r_x;
    logic [LW-1:0]     r_limb;
    logic [AW-1:0]     r_clr;
    logic [LB-1:0]     r_rda, r_rdb;
    logic [PW-1:0]     r_prod;
    logic [LB:0]       r_carry;
    logic [LB-1:0]     r_rem, r_shf, r_quo;
    logic [LB-1:0]     r_rd;
    logic [LEAD_W-1:0] r_lead;
    logic              r_ovf;

    logic [LW-1:0]     w_idx_limb;
    logic [AW-1:0]     w_ra, w_rb, w_wa;
    logic [LB-1:0]     w_wd;
    logic              w_we;
    logic [2*LB-1:0]   w_mul;
    logic [TW-1:0]     w_t;
    logic [LB:0]       w_arith_carry;
    logic [LB:0]       w_round_sum;
    logic [LB:0]       w_rem2;
    logic              w_ge;
    logic              w_idx_ok;

    assign w_idx_limb    = LW'(r_idx);
    assign w_idx_ok      = 32'(r_idx) < LIMBS;
    assign w_mul         = {{LB{1'b0}}, r_rda} * {{LB{1'b0}}, r_x};
    assign w_round_sum   = {1'b0, r_rda} + (LB+1)'(1);
    assign w_rem2        = {r_rem, r_shf[LB-1]};
    assign w_ge          = w_rem2 >= {1'b0, r_x};

    // carry chain: subtract keeps a one-bit borrow, add and multiply a full carry limb
    always_comb begin
        if (r_mode == MODE_SUB) begin
            w_t           = TW'(r_rda) - TW'(r_rdb) - TW'(r_carry[0]);
            w_arith_carry = (LB+1)'(w_t[LB]);
        end else begin
            w_t           = TW'(r_prod) + TW'(r_carry);
            w_arith_carry = w_t[2*LB:LB];
        end
    end

    always_comb begin
        w_ra = addr_of(r_sa, r_limb);
        w_rb = addr_of(r_sb, r_limb);
        unique case (i_cmd.rd_sel)
            RS_C_LIMB: w_ra = addr_of(r_sc, r_limb);
            RS_C_IDX:  w_ra = addr_of(r_sc, w_idx_limb);
            default:   w_ra = addr_of(r_sa, r_limb);
        endcase
    end

    always_comb begin
        w_we = 1'b0;
        w_wa = addr_of(r_sc, r_limb);
        w_wd = '0;
        unique case (i_cmd.wr_sel)
            WS_WRITE_LIMB: begin
                w_we = w_idx_ok;
                w_wa = addr_of(r_sc, w_idx_limb);
                w_wd = r_val;
            end
            WS_ARITH: begin
                w_we = 1'b1;
                w_wd = w_t[LB-1:0];
            end
            WS_QUOT: begin
                w_we = 1'b1;
                w_wd = r_quo;
            end
            WS_ROUND: begin
                w_we = 1'b1;
                w_wd = w_round_sum[LB-1:0];
            end
            WS_CLEAR: begin
                w_we = 1'b1;
                w_wa = r_clr;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        if (i_cmd.rd_en) begin
            r_rda <= mem[w_ra];
            r_rdb <= mem[w_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.wr_sel == WS_CLEAR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_sa   <= slot_mod(i_src_a);
            r_sb   <= slot_mod(i_src_b);
            r_sc   <= slot_mod(i_dst);
            r_idx  <= i_limb_index;
            r_val  <= i_limb_value;
            r_x    <= i_scalar;
        end

        unique case (i_cmd.limb_op)
            LOP_LAST: r_limb <= LW'(LIMBS - 1);
            LOP_IDX:  r_limb <= w_idx_limb;
            LOP_INC:  r_limb <= r_limb + 1'b1;
            LOP_DEC:  r_limb <= r_limb - 1'b1;
            default:  r_limb <= r_limb;
        endcase

        if (i_cmd.prod_ld) begin
            if (r_mode == MODE_MUL) r_prod <= PW'(w_mul);
            else r_prod <= PW'(r_rda) + PW'(r_rdb);
        end

        if (i_cmd.carry_clr) r_carry <= '0;
        else if (i_cmd.wr_sel == WS_ARITH) r_carry <= w_arith_carry;

        if (i_cmd.rem_clr) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? LB'(w_rem2 - {1'b0, r_x}) : LB'(w_rem2);
        end
        if (i_cmd.div_init) begin
            r_shf <= r_rda;
        end else if (i_cmd.div_step) begin
            r_shf <= {r_shf[LB-2:0], 1'b0};
            r_quo <= {r_quo[LB-2:0], w_ge};
        end

        if (i_cmd.load) begin
            r_rd   <= '0;
            r_lead <= '0;
            r_ovf  <= 1'b0;
        end else begin
            unique case (i_cmd.res)
                RES_READ:     r_rd   <= r_rda;
                RES_LEAD:     r_lead <= (r_rda != '0) ? {1'b0, r_idx}
                                                      : {1'b0, r_idx} + LEAD_W'(1);
                RES_LEAD_MAX: r_lead <= LEAD_W'(LIMBS);
                RES_OVF_SET:  r_ovf  <= 1'b1;
                default:      r_rd   <= r_rd;
            endcase
            if (i_cmd.ovf_upd) begin
                if (i_cmd.wr_sel == WS_ROUND) r_ovf <= w_round_sum[LB];
                else r_ovf <= (w_arith_carry != '0);
            end
        end
    end

    assign o_sts.mode        = r_mode;
    assign o_sts.idx_ok      = w_idx_ok;
    assign o_sts.x_zero      = (r_x == '0);
    assign o_sts.limb_first  = (r_limb == '0);
    assign o_sts.limb_last   = (r_limb == LW'(LIMBS - 1));
    assign o_sts.round_up    = {r_rem, 1'b0} >= {1'b0, r_x};
    assign o_sts.round_carry = w_round_sum[LB];
    assign o_sts.clr_last    = (r_clr == AW'(DEPTH - 1));

    assign o_read_value    = r_rd;
    assign o_leading_index = r_lead;
    assign o_overflow      = r_ovf;

endmodule

`default_nettype wire

// ===== tb/sv/mpla_limb_checker.sv =====
// Scoreboard for the multiprecision limb ALU: mirrors the limb store, predicts
// one result per accepted operation and compares it with the output channel.
// Depends on mpla_pkg, mpla_in_if and mpla_out_if.
`timescale 1ns / 1ps

module mpla_limb_checker
    import mpla_pkg::*;
#(
    parameter int LIMBS   = LIMBS_DEF,
    parameter int NUMBERS = NUMBERS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mpla_in_if.sink  i_in_mon,
    mpla_out_if.sink i_out_mon,
    output int   o_fail_cnt,
    output int   o_pending,
    output int   o_ops_seen,
    output int   o_ovf_seen
);
    typedef struct packed {
        logic [LIMB_BITS-1:0] read_value;
        logic [LEAD_W-1:0]    leading_index;
        logic                 overflow;
    } t_alu_result;

    logic [LIMB_BITS-1:0] limb_mirror [NUMBERS*LIMBS];
    t_alu_result          result_queue [$];

    function automatic t_alu_result apply_op(input logic [MODE_W-1:0] mode,
            input logic [SLOT_W-1:0] sa, input logic [SLOT_W-1:0] sb,
            input logic [SLOT_W-1:0] sd, input logic [IDX_W-1:0] idx,
            input logic [LIMB_BITS-1:0] val, input logic [LIMB_BITS-1:0] x);
        t_alu_result r;
        int          ab;
        int          bb;
        int          cb;
        longint      t;
        longint      s;
        int          carry;
        r  = '0;
        ab = (sa % NUMBERS) * LIMBS;
        bb = (sb % NUMBERS) * LIMBS;
        cb = (sd % NUMBERS) * LIMBS;
        t  = 0;
        case (mode)
            MODE_WRITE: begin
                if (idx < LIMBS) limb_mirror[cb+idx] = val;
            end
            MODE_READ: begin
                if (idx < LIMBS) r.read_value = limb_mirror[cb+idx];
            end
            MODE_ADD: begin
                for (int i = LIMBS - 1; i >= 0; i--) begin
                    t = t + limb_mirror[ab+i] + limb_mirror[bb+i];
                    limb_mirror[cb+i] = t[LIMB_BITS-1:0];
                    t = t >> LIMB_BITS;
                end
                r.overflow = (t != 0);
            end
            MODE_SUB: begin
                for (int i = LIMBS - 1; i >= 0; i--) begin
                    t = longint'(limb_mirror[ab+i]) - limb_mirror[bb+i] - t;
                    limb_mirror[cb+i] = t[LIMB_BITS-1:0];
                    t = (t < 0) ? 1 : 0;
                end
                r.overflow = (t != 0);
            end
            MODE_MUL: begin
                for (int i = LIMBS - 1; i >= 0; i--) begin
                    t = t + longint'(limb_mirror[ab+i]) * x;
                    limb_mirror[cb+i] = t[LIMB_BITS-1:0];
                    t = t >> LIMB_BITS;
                end
                r.overflow = (t != 0);
            end
            MODE_DIV: begin
                if (x == 0) begin
                    r.overflow = 1'b1;
                end else if (idx >= LIMBS) begin
                    r.leading_index = LEAD_W'(LIMBS);
                end else begin
                    for (int i = idx; i < LIMBS; i++) begin
                        t = (t << LIMB_BITS) + limb_mirror[ab+i];
                        limb_mirror[cb+i] = LIMB_BITS'(t / x);
                        t = t % x;
                    end
                    // round half up, ripple the carry toward the integer limb
                    if (2 * t >= x) begin
                        carry = 1;
                        for (int i = LIMBS - 1; i >= 0 && carry != 0; i--) begin
                            s = longint'(limb_mirror[cb+i]) + 1;
                            limb_mirror[cb+i] = s[LIMB_BITS-1:0];
                            carry = int'(s >> LIMB_BITS);
                        end
                        r.overflow = (carry != 0);
                    end
                    r.leading_index = (limb_mirror[cb+idx] != 0)
                                      ? LEAD_W'(idx) : LEAD_W'(idx) + LEAD_W'(1);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alu_result want;
        t_alu_result got;
        if (!i_rst_n) begin
            foreach (limb_mirror[k]) limb_mirror[k] = '0;
            result_queue.delete();
            o_fail_cnt = 0;
            o_ops_seen = 0;
            o_ovf_seen = 0;
            o_pending  = 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.read_value    = i_out_mon.read_value;
                got.leading_index = i_out_mon.leading_index;
                got.overflow      = i_out_mon.overflow;
                if (result_queue.size() == 0) begin
                    o_fail_cnt++;
                    if (o_fail_cnt <= 10)
                        $display("unexpected result rd=%0d lead=%0d ovf=%0d",
                                 got.read_value, got.leading_index, got.overflow);
                end else begin
                    want = result_queue.pop_front();
                    if (got.overflow) o_ovf_seen++;
                    if (got !== want) begin
                        o_fail_cnt++;
                        if (o_fail_cnt <= 10)
                            $display("mismatch: exp rd=%0d lead=%0d ovf=%0d got rd=%0d lead=%0d ovf=%0d",
                                     want.read_value, want.leading_index, want.overflow,
                                     got.read_value, got.leading_index, got.overflow);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                o_ops_seen++;
                result_queue.push_back(apply_op(i_in_mon.mode, i_in_mon.src_a,
                    i_in_mon.src_b, i_in_mon.dst, i_in_mon.limb_index,
                    i_in_mon.limb_value, i_in_mon.scalar));
            end
            o_pending = result_queue.size();
        end
    end
endmodule

// ===== tb/sv/multiprecision_limb_alu_unit_tb.sv =====
// Top of the multiprecision limb ALU testbench: clock, reset, operation stimulus,
// output back-pressure, watchdog and verdict. Depends on mpla_pkg, the channel
// interfaces, mpla_limb_checker and multiprecision_limb_alu_unit.
`timescale 1ns / 1ps

module multiprecision_limb_alu_unit_tb;
    import mpla_pkg::*;

    localparam int RANDOM_OPS   = 120;
    // longest item is a divide from limb 0 plus a full ripple, plus stalls
    localparam int IDLE_LIMIT   = 40000;
    localparam int DRAIN_CYCLES = 6000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_cnt;
    int   pending;
    int   ops_seen;
    int   ovf_seen;
    int   idle_cycles = 0;
    bit   stim_done = 1'b0;
    bit   hold_off = 1'b0;

    mpla_in_if  in_ch ();
    mpla_out_if out_ch ();

    always #1 i_clk = ~i_clk;

    multiprecision_limb_alu_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    mpla_limb_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_mon   (in_ch.sink),
        .i_out_mon  (out_ch.sink),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_ops_seen (ops_seen),
        .o_ovf_seen (ovf_seen)
    );

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_WRITE;
        in_ch.src_a      = '0;
        in_ch.src_b      = '0;
        in_ch.dst        = '0;
        in_ch.limb_index = '0;
        in_ch.limb_value = '0;
        in_ch.scalar     = '0;
        out_ch.ready     = 1'b0;
    end

    // Present one operation, hold it until the transaction, then drop valid
    // unless the next item follows with no gap.
    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [1:0] sa,
            input logic [1:0] sb, input logic [1:0] sd, input logic [7:0] idx,
            input logic [14:0] val, input logic [14:0] x);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= mode;
        in_ch.src_a      <= sa;
        in_ch.src_b      <= sb;
        in_ch.dst        <= sd;
        in_ch.limb_index <= idx;
        in_ch.limb_value <= val;
        in_ch.scalar     <= x;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_start();
        // mostly starts near the last limb so divides stay short
        return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(200, 255));
    endfunction

    // Stimulus: directed corners, then random sequences that include unused mode codes.
    initial begin
        int kind;
        logic [1:0] d;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // load extremes into slots: all-ones limbs 0 and 255 in slot 1, small pattern in slot 2
        send_op(MODE_WRITE, 2'd0, 2'd0, 2'd1, 8'd0,   15'h7FFF, 15'd0);
        send_op(MODE_WRITE, 2'd0, 2'd0, 2'd1, 8'd255, 15'h7FFF, 15'd0);
        send_op(MODE_WRITE, 2'd0, 2'd0, 2'd2, 8'd255, 15'd1, 15'd0);
        send_op(MODE_WRITE, 2'd0, 2'd0, 2'd2, 8'd0,   15'h5555, 15'd0);
        send_op(MODE_READ,  2'd0, 2'd0, 2'd1, 8'd0,   15'd0, 15'd0);
        send_op(MODE_READ,  2'd0, 2'd0, 2'd1, 8'd255, 15'd0, 15'd0);
        send_op(MODE_ADD,   2'd1, 2'd2, 2'd3, 8'd0, 15'd0, 15'd0);   // carry out of limb 0
        send_op(MODE_SUB,   2'd0, 2'd2, 2'd0, 8'd0, 15'd0, 15'd0);   // borrow out of limb 0
        send_op(MODE_ADD,   2'd2, 2'd2, 2'd2, 8'd0, 15'd0, 15'd0);   // in place
        send_op(MODE_MUL,   2'd1, 2'd0, 2'd3, 8'd0, 15'd0, 15'h7FFF);
        send_op(MODE_MUL,   2'd2, 2'd0, 2'd2, 8'd0, 15'd0, 15'd0);
        send_op(MODE_WRITE, 2'd0, 2'd0, 2'd2, 8'd254, 15'h2AAA, 15'd0);
        send_op(MODE_DIV,   2'd1, 2'd0, 2'd3, 8'd250, 15'd0, 15'd0);    // zero divisor
        send_op(MODE_DIV,   2'd1, 2'd0, 2'd3, 8'd250, 15'd0, 15'd3);    // remainder below half, no round up
        send_op(MODE_DIV,   2'd2, 2'd0, 2'd2, 8'd253, 15'd0, 15'h7FFF); // quotient limb zero
        send_op(MODE_DIV,   2'd1, 2'd0, 2'd0, 8'd255, 15'd0, 15'd1);
        send_op(MODE_DIV,   2'd1, 2'd0, 2'd1, 8'd0,   15'd0, 15'd2);    // full length divide
        send_op(MODE_READ,  2'd0, 2'd0, 2'd3, 8'd251, 15'd0, 15'd0);
        send_op(3'd6,       2'd3, 2'd3, 2'd3, 8'hFF, 15'h7FFF, 15'h7FFF);
        send_op(3'd7,       2'd0, 2'd0, 2'd0, 8'd0, 15'd0, 15'd0);
        send_op(MODE_READ,  2'd0, 2'd0, 2'd0, 8'd128, 15'd0, 15'd0);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            kind = $urandom_range(0, 99);
            d    = 2'($urandom());
            if (kind < 30)
                send_op(MODE_WRITE, 2'd0, 2'd0, d, 8'($urandom()), 15'($urandom()),
                        15'd0);
            else if (kind < 45)
                send_op(MODE_READ, 2'd0, 2'd0, d, 8'($urandom()), 15'd0, 15'd0);
            else if (kind < 58)
                send_op(MODE_ADD, 2'($urandom()), 2'($urandom()), d, 8'd0, 15'd0, 15'd0);
            else if (kind < 70)
                send_op(MODE_SUB, 2'($urandom()), 2'($urandom()), d, 8'd0, 15'd0, 15'd0);
            else if (kind < 80)
                send_op(MODE_MUL, 2'($urandom()), 2'd0, d, 8'd0, 15'd0, 15'($urandom()));
            else if (kind < 97)
                send_op(MODE_DIV, 2'($urandom()), 2'd0, d, rand_start(), 15'd0,
                        ($urandom_range(0, 9) == 0) ? 15'd0
                                                    : 15'($urandom_range(1, 32767)));
            else
                send_op(3'($urandom_range(6, 7)), 2'($urandom()), 2'($urandom()), d,
                        8'($urandom()), 15'($urandom()), 15'($urandom()));
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls per result, with one long hold-off early on.
    initial begin
        int stall;
        wait (i_rst_n);
        repeat (200) @(posedge i_clk);
        hold_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge i_clk);
        hold_off = 1'b0;
        forever begin
            stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    // Watchdog: count cycles with no transaction on either side, outside reset and the hold-off.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off
                || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog expired: %0d results outstanding", pending);
            $display("FAIL multiprecision_limb_alu_unit");
            $finish;
        end
    end

    // Verdict once everything has drained.
    initial begin
        wait (stim_done);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d operations over all modes, %0d overflow results",
                 ops_seen, ovf_seen);
        if (fail_cnt == 0 && pending == 0)
            $display("PASS multiprecision_limb_alu_unit");
        else
            $display("FAIL multiprecision_limb_alu_unit");
        $finish;
    end
endmodule
